### rtl/rau_pkg.sv
// shared types, constants and widths for the rational arithmetic unit
package rau_pkg;

  // operand and derived datapath widths
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned DenWidth     = OperandWidth - 1;
  localparam int unsigned ProdWidth    = 2 * OperandWidth;
  localparam int unsigned MagWidth     = ProdWidth - 1;
  localparam int unsigned ShiftWidth   = $clog2(MagWidth + 1);
  localparam int unsigned ExtWidth     = (ProdWidth > 32) ? ProdWidth : 32;
  localparam int unsigned ResNumWidth  = 32;
  localparam int unsigned ResDenWidth  = 31;

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CHECK,
    ST_GCD_TWO,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_FINISH
  } state_e;

  // request payload
  typedef struct packed {
    logic [2:0]                     op;
    logic signed [OperandWidth-1:0] a_num;
    logic [DenWidth-1:0]            a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic [DenWidth-1:0]            b_den;
  } req_t;

  // result payload
  typedef struct packed {
    logic signed [ResNumWidth-1:0] res_num;
    logic [ResDenWidth-1:0]        res_den;
    logic                          div_by_zero;
    logic                          is_equal;
    logic                          is_less;
    logic                          is_greater;
  } res_t;

endpackage

### rtl/rau_div.sv
// iterative restoring divider, one quotient bit per cycle
module rau_div #(
  parameter int unsigned WIDTH = rau_pkg::MagWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] quotient_o,
  output logic             done_o
);

  localparam int unsigned CntWidth = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]    rem_q, rem_d;
  logic [WIDTH-1:0]    quo_q, quo_d;
  logic [WIDTH-1:0]    dvs_q, dvs_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [WIDTH:0]      trial;
  logic                fits;

  // trial subtraction of the shifted remainder
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  // next state of the divider
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntWidth'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? WIDTH'(trial - {1'b0, dvs_q}) : trial[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### rtl/rational_arithmetic_unit_core.sv
// rational arithmetic unit: cross products, binary gcd and reduction to lowest terms
// compare, divide by zero, zero result and unused ops skip the gcd and divider;
//   other ops run the shared multiplier, the binary gcd loop and the bit-serial divider
// throughput: one request at a time, busy stays high through the result strobe,
//   so a new request is taken at the earliest in the cycle after the strobe
// the result is shown for one cycle with done_o and cannot be stalled
// reset is asynchronous and active low and returns the sequencer to idle
module rational_arithmetic_unit_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rau_pkg::req_t req_i,
  output rau_pkg::res_t res_o,
  output logic          done_o
);

  localparam int unsigned OW = rau_pkg::OperandWidth;
  localparam int unsigned PW = rau_pkg::ProdWidth;
  localparam int unsigned MW = rau_pkg::MagWidth;
  localparam int unsigned KW = rau_pkg::ShiftWidth;
  localparam int unsigned XW = rau_pkg::ExtWidth;

  rau_pkg::state_e state_q, state_d;
  rau_pkg::req_t   req_q, req_d;
  rau_pkg::res_t   res_q, res_d;

  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [PW-1:0] num_q, num_d;
  logic signed [PW-1:0] den_q, den_d;
  logic [MW-1:0]        mag_q, mag_d;
  logic [MW-1:0]        dm_q, dm_d;
  logic [MW-1:0]        u_q, u_d;
  logic [MW-1:0]        v_q, v_d;
  logic [MW-1:0]        g_q, g_d;
  logic [MW-1:0]        qnum_q, qnum_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 neg_q, neg_d;

  logic signed [OW-1:0] mul_x, mul_y;
  logic signed [OW-1:0] ad_s, bd_s;
  logic signed [PW-1:0] product;
  logic signed [PW-1:0] num_abs, den_abs;
  logic signed [PW-1:0] num_signed;
  logic signed [XW-1:0] num_ext;
  logic [XW-1:0]        den_ext;
  logic [MW-1:0]        g_now;
  logic                 op_bad, gcd_even, gcd_end;

  logic          div_start;
  logic [MW-1:0] div_dividend, div_divisor, div_quot;
  logic          div_done;

  // shared multiplier operand selection
  assign ad_s = {1'b0, req_q.a_den};
  assign bd_s = {1'b0, req_q.b_den};

  always_comb begin
    unique case (state_q)
      rau_pkg::ST_MUL0: begin
        mul_x = req_q.a_num;
        mul_y = (req_q.op == rau_pkg::OP_MUL) ? req_q.b_num : bd_s;
      end
      rau_pkg::ST_MUL1: begin
        mul_x = ad_s;
        mul_y = req_q.b_num;
      end
      default: begin
        mul_x = ad_s;
        mul_y = ((req_q.op == rau_pkg::OP_DIV) || (req_q.op == rau_pkg::OP_CMP))
                ? req_q.b_num : bd_s;
      end
    endcase
  end

  assign product = mul_x * mul_y;

  // status terms
  assign op_bad   = (req_q.op > rau_pkg::OP_CMP);
  assign num_abs  = num_q[PW-1] ? -num_q : num_q;
  assign den_abs  = den_q[PW-1] ? -den_q : den_q;
  assign gcd_even = !u_q[0] && !v_q[0];
  assign gcd_end  = (u_q == v_q);
  assign g_now    = u_q << k_q;

  // signed quotient, extended and cut to the result widths
  assign num_signed = neg_q ? -$signed({1'b0, qnum_q}) : $signed({1'b0, qnum_q});
  assign num_ext    = XW'(num_signed);
  assign den_ext    = XW'(div_quot);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rau_pkg::ST_IDLE:    if (start) state_d = rau_pkg::ST_MUL0;
      rau_pkg::ST_MUL0:    state_d = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1:    state_d = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2:    state_d = rau_pkg::ST_MUL3;
      rau_pkg::ST_MUL3:    state_d = rau_pkg::ST_CHECK;
      rau_pkg::ST_CHECK: begin
        if (op_bad || (req_q.op == rau_pkg::OP_CMP) ||
            ((req_q.op == rau_pkg::OP_DIV) && (req_q.b_num == '0)) ||
            (den_q == '0) || (num_q == '0)) begin
          state_d = rau_pkg::ST_FINISH;
        end else begin
          state_d = rau_pkg::ST_GCD_TWO;
        end
      end
      rau_pkg::ST_GCD_TWO: if (!gcd_even) state_d = rau_pkg::ST_GCD;
      rau_pkg::ST_GCD:     if (gcd_end) state_d = rau_pkg::ST_DIV_NUM;
      rau_pkg::ST_DIV_NUM: if (div_done) state_d = rau_pkg::ST_DIV_DEN;
      rau_pkg::ST_DIV_DEN: if (div_done) state_d = rau_pkg::ST_FINISH;
      rau_pkg::ST_FINISH:  state_d = rau_pkg::ST_IDLE;
      default:             state_d = rau_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d        = req_q;
    res_d        = res_q;
    prod_d       = product;
    num_d        = num_q;
    den_d        = den_q;
    mag_d        = mag_q;
    dm_d         = dm_q;
    u_d          = u_q;
    v_d          = v_q;
    g_d          = g_q;
    qnum_d       = qnum_q;
    k_d          = k_q;
    neg_d        = neg_q;
    div_start    = 1'b0;
    div_dividend = mag_q;
    div_divisor  = g_now;
    unique case (state_q)
      rau_pkg::ST_IDLE: begin
        if (start) req_d = req_i;
      end
      rau_pkg::ST_MUL1: begin
        num_d = prod_q;
      end
      rau_pkg::ST_MUL2: begin
        if (req_q.op == rau_pkg::OP_ADD) begin
          num_d = num_q + prod_q;
        end else if (req_q.op == rau_pkg::OP_SUB) begin
          num_d = num_q - prod_q;
        end
      end
      rau_pkg::ST_MUL3: begin
        den_d = prod_q;
      end
      rau_pkg::ST_CHECK: begin
        res_d = '0;
        if (op_bad) begin
          res_d = '0;
        end else if (req_q.op == rau_pkg::OP_CMP) begin
          res_d.is_equal   = (num_q == den_q);
          res_d.is_less    = (num_q < den_q);
          res_d.is_greater = (num_q > den_q);
        end else if ((req_q.op == rau_pkg::OP_DIV) && (req_q.b_num == '0)) begin
          res_d.div_by_zero = 1'b1;
        end else if (den_q == '0) begin
          res_d = '0;
        end else if (num_q == '0) begin
          res_d.res_den = rau_pkg::ResDenWidth'(1);
        end else begin
          mag_d = num_abs[MW-1:0];
          dm_d  = den_abs[MW-1:0];
          u_d   = num_abs[MW-1:0];
          v_d   = den_abs[MW-1:0];
          k_d   = '0;
          neg_d = num_q[PW-1] ^ den_q[PW-1];
        end
      end
      rau_pkg::ST_GCD_TWO: begin
        // strip common factors of two
        if (gcd_even) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end
      end
      rau_pkg::ST_GCD: begin
        // binary gcd step on odd-part values
        if (gcd_end) begin
          g_d       = g_now;
          div_start = 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q > v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      rau_pkg::ST_DIV_NUM: begin
        div_dividend = dm_q;
        div_divisor  = g_q;
        if (div_done) begin
          qnum_d    = div_quot;
          div_start = 1'b1;
        end
      end
      rau_pkg::ST_DIV_DEN: begin
        if (div_done) begin
          res_d         = '0;
          res_d.res_num = num_ext[rau_pkg::ResNumWidth-1:0];
          res_d.res_den = den_ext[rau_pkg::ResDenWidth-1:0];
        end
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // shared divider for the two reductions
  rau_div #(
    .WIDTH(MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    den_q  <= den_d;
    mag_q  <= mag_d;
    dm_q   <= dm_d;
    u_q    <= u_d;
    v_q    <= v_d;
    g_q    <= g_d;
    qnum_q <= qnum_d;
    k_q    <= k_d;
    neg_q  <= neg_d;
  end

  assign busy   = (state_q != rau_pkg::ST_IDLE);
  assign done_o = (state_q == rau_pkg::ST_FINISH);
  assign res_o  = res_q;

endmodule

### bench/tb_rational_arithmetic_unit_core.sv
// self-checking testbench for the rational arithmetic unit core
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit_core;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 11;
  localparam int unsigned RandomItems  = 600;
  localparam int unsigned DrainEvery   = 150;
  localparam int unsigned SettleCycles = 160;
  localparam int unsigned CycleLimit   = 900000;

  // op codes the block does not define
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  rau_pkg::req_t req_i;
  rau_pkg::res_t res_o;
  logic          done_o;

  rau_pkg::res_t expected_fractions[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  rational_arithmetic_unit_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .res_o  (res_o),
    .done_o (done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // euclid on magnitudes
  function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // expected result of one request: cross products, then lowest terms
  function automatic rau_pkg::res_t predict_fraction(rau_pkg::req_t rq);
    rau_pkg::res_t res;
    longint an, ad, bn, bd, num, den, lhs, rhs, signed_num;
    longint unsigned mag, dm, g;
    bit neg;
    res = '0;
    an  = longint'(rq.a_num);
    bn  = longint'(rq.b_num);
    ad  = longint'({1'b0, rq.a_den});
    bd  = longint'({1'b0, rq.b_den});
    num = 0;
    den = 0;
    case (rq.op)
      rau_pkg::OP_ADD: begin
        num = an * bd + ad * bn;
        den = ad * bd;
      end
      rau_pkg::OP_SUB: begin
        num = an * bd - ad * bn;
        den = ad * bd;
      end
      rau_pkg::OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      rau_pkg::OP_DIV: begin
        if (bn == 0) begin
          res.div_by_zero = 1'b1;
          return res;
        end
        num = an * bd;
        den = ad * bn;
      end
      rau_pkg::OP_CMP: begin
        lhs = an * bd;
        rhs = ad * bn;
        res.is_equal   = (lhs == rhs);
        res.is_less    = (lhs < rhs);
        res.is_greater = (lhs > rhs);
        return res;
      end
      default: return res;
    endcase
    // zero denominator from the products gives 0/0 with no flags
    if (den == 0) return res;
    neg = 1'b0;
    if (den < 0) begin
      dm  = longint'(-den);
      neg = 1'b1;
    end else begin
      dm = den;
    end
    if (num < 0) begin
      mag = longint'(-num);
      neg = ~neg;
    end else begin
      mag = num;
    end
    // zero comes out as 0/1
    if (mag == 0) begin
      res.res_den = 31'd1;
      return res;
    end
    g   = gcd_mag(mag, dm);
    mag = mag / g;
    dm  = dm / g;
    signed_num  = neg ? -longint'(mag) : longint'(mag);
    res.res_num = signed_num[31:0];
    res.res_den = dm[30:0];
    return res;
  endfunction

  function automatic rau_pkg::req_t make_req(logic [2:0] op, int an, int ad, int bn, int bd);
    rau_pkg::req_t rq;
    rq.op    = op;
    rq.a_num = an[15:0];
    rq.a_den = ad[14:0];
    rq.b_num = bn[15:0];
    rq.b_den = bd[14:0];
    return rq;
  endfunction

  // numerators: extremes, zero, small values that share factors, full random
  function automatic logic [15:0] rand_num();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(40)) - 20);
      5: return 16'($signed($urandom_range(2000)) - 1000);
      default: return r[15:0];
    endcase
  endfunction

  // denominators: mostly legal, with an occasional zero
  function automatic logic [14:0] rand_den();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(19))
      0: return 15'd0;
      1: return 15'h7fff;
      2: return 15'd1;
      3, 4, 5: return 15'($urandom_range(1, 24));
      6, 7: return 15'($urandom_range(1, 1000));
      default: return (r[14:0] == 0) ? 15'd1 : r[14:0];
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    if ($urandom_range(29) == 0) return 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    return 3'($urandom_range(rau_pkg::OP_ADD, rau_pkg::OP_CMP));
  endfunction

  // idle gap: mostly none or short, a few long
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(40, 150);
  endfunction

  // send one request, wait until busy drops, then record its expected result
  task automatic send_request(rau_pkg::req_t rq, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_fractions.push_back(predict_fraction(rq));
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk_i);
  endtask

  // plain cases of every operation
  task automatic test_each_op();
    send_request(make_req(rau_pkg::OP_ADD, 1, 2, 1, 3), rand_gap());
    send_request(make_req(rau_pkg::OP_SUB, 1, 2, 1, 3), rand_gap());
    send_request(make_req(rau_pkg::OP_MUL, -3, 4, 2, 9), rand_gap());
    send_request(make_req(rau_pkg::OP_DIV, 1, 2, -3, 4), rand_gap());
    send_request(make_req(rau_pkg::OP_CMP, 1, 3, 1, 2), rand_gap());
    send_request(make_req(rau_pkg::OP_CMP, 1, 2, 2, 4), rand_gap());
    send_request(make_req(rau_pkg::OP_CMP, 3, 4, -5, 6), rand_gap());
  endtask

  // field extremes, where products reach their widest
  task automatic test_extremes();
    send_request(make_req(rau_pkg::OP_ADD, -32768, 32767, 32767, 32767), rand_gap());
    send_request(make_req(rau_pkg::OP_ADD, -32768, 1, -32768, 1), rand_gap());
    send_request(make_req(rau_pkg::OP_SUB, -32768, 1, 32767, 1), rand_gap());
    send_request(make_req(rau_pkg::OP_SUB, 32767, 32767, -32768, 1), rand_gap());
    send_request(make_req(rau_pkg::OP_MUL, -32768, 1, -32768, 1), rand_gap());
    send_request(make_req(rau_pkg::OP_MUL, -32768, 32767, 32767, 1), rand_gap());
    send_request(make_req(rau_pkg::OP_DIV, -32768, 1, -1, 32767), rand_gap());
    send_request(make_req(rau_pkg::OP_DIV, 32767, 32767, -32768, 32767), rand_gap());
    send_request(make_req(rau_pkg::OP_CMP, -32768, 1, 32767, 32767), rand_gap());
  endtask

  // divide by zero, zero result, zero denominators, unused op codes
  task automatic test_special_cases();
    send_request(make_req(rau_pkg::OP_DIV, 5, 7, 0, 3), rand_gap());
    send_request(make_req(rau_pkg::OP_SUB, 1, 2, 2, 4), rand_gap());
    send_request(make_req(rau_pkg::OP_MUL, 0, 9, -7, 5), rand_gap());
    send_request(make_req(rau_pkg::OP_ADD, 3, 0, 1, 2), rand_gap());
    send_request(make_req(rau_pkg::OP_MUL, 3, 4, 1, 0), rand_gap());
    send_request(make_req(rau_pkg::OP_DIV, 3, 0, 1, 2), rand_gap());
    send_request(make_req(rau_pkg::OP_CMP, 3, 0, 1, 0), rand_gap());
    send_request(make_req(OpUnusedLo, 1, 2, 3, 4), rand_gap());
    send_request(make_req(OpUnusedHi, -1, 32767, -1, 32767), rand_gap());
  endtask

  // random requests with bursts of back-to-back traffic and periodic drains
  task automatic test_random();
    rau_pkg::req_t rq;
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      rq.op    = rand_op();
      rq.a_num = rand_num();
      rq.a_den = rand_den();
      rq.b_num = rand_num();
      rq.b_den = rand_den();
      if (burst == 0 && $urandom_range(39) == 0) burst = $urandom_range(10, 30);
      if (burst > 0) begin
        burst--;
        send_request(rq, 0);
      end else begin
        send_request(rq, rand_gap());
      end
      if (i % DrainEvery == DrainEvery - 1) wait_for_results();
    end
  endtask

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_fractions.size() == 0) begin
        $error("result with no request outstanding: res_num %0d res_den %0d",
               res_o.res_num, res_o.res_den);
        mismatch_count++;
      end else begin
        rau_pkg::res_t exp_res;
        exp_res = expected_fractions.pop_front();
        if (res_o.res_num !== exp_res.res_num) begin
          $error("res_num: expected %0d, got %0d", exp_res.res_num, res_o.res_num);
          mismatch_count++;
        end
        if (res_o.res_den !== exp_res.res_den) begin
          $error("res_den: expected %0d, got %0d", exp_res.res_den, res_o.res_den);
          mismatch_count++;
        end
        if (res_o.div_by_zero !== exp_res.div_by_zero) begin
          $error("div_by_zero: expected %0b, got %0b", exp_res.div_by_zero,
                 res_o.div_by_zero);
          mismatch_count++;
        end
        if (res_o.is_equal !== exp_res.is_equal) begin
          $error("is_equal: expected %0b, got %0b", exp_res.is_equal, res_o.is_equal);
          mismatch_count++;
        end
        if (res_o.is_less !== exp_res.is_less) begin
          $error("is_less: expected %0b, got %0b", exp_res.is_less, res_o.is_less);
          mismatch_count++;
        end
        if (res_o.is_greater !== exp_res.is_greater) begin
          $error("is_greater: expected %0b, got %0b", exp_res.is_greater,
                 res_o.is_greater);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_op();
    test_extremes();
    test_special_cases();
    wait_for_results();
    test_random();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
